### hdl/fdpc_pkg.sv
// Shared widths, operation codes, queue word and back-end state type.
`timescale 1ns / 1ps
`default_nettype none

package fdpc_pkg;

    localparam int PIX_W  = 16;                 // light pixel and result
    localparam int FRAC_W = 8;                  // Q16.8 fraction bits
    localparam int MST_W  = PIX_W + FRAC_W;     // master values
    localparam int PC_W   = 25;                 // pixel count register
    localparam int SUM_W  = 48;                 // flat sum
    localparam int OP_W   = 2;
    localparam int HALF_W = SUM_W / 2;          // flat sum split for the multiplier
    localparam int PP_W   = MST_W + HALF_W;     // one partial product
    localparam int PROD_W = MST_W + SUM_W;      // full numerator
    localparam int DEN_W  = MST_W + PC_W;       // (flat - bias) * pixel_count
    localparam int DIV_W  = DEN_W + FRAC_W;     // divisor, Q.8 aligned
    localparam int Q_W    = PIX_W + 1;          // quotient with one half bit
    localparam int CNT_W  = $clog2(Q_W);
    localparam int SAT_SH = PIX_W + FRAC_W;     // divisor shift for the range check

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
    localparam logic [OP_W-1:0] OP_CALIB = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // one calibrate word as classified by the front end
    typedef struct packed {
        logic             divide;   // needs the multiply/divide path
        logic [PIX_W-1:0] pix;      // result when divide is low
        logic             zflag;
        logic             eos;
        logic [MST_W-1:0] nmag;
        logic [MST_W-1:0] dmag;
        logic [SUM_W-1:0] fsum;
        logic [PC_W-1:0]  pcount;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL0  = 7'b0000010,
        ST_MUL1  = 7'b0000100,
        ST_MUL2  = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_ROUND = 7'b1000000
    } t_back_state;

endpackage

`default_nettype wire

### hdl/flat_dark_pixel_calibration.sv
// Top level of the flat/dark pixel calibration block.
`timescale 1ns / 1ps
`default_nettype none

// Accumulate and clear words finish in the cycle they are taken and give no result.
// A calibrate word is classified on entry and queued (two entries); busy is high
// while that queue is full. Calibrate words that need no division (zero denominator,
// zero numerator or a negative quotient) give their result through the queue and the
// output register once the back end takes them. All others run through the back end:
// the dequeue, split multiplies in MUL0 and MUL1 and a final add in MUL2 for the
// numerator (the denominator product in MUL0), a range check that catches saturated
// quotients, 17 restoring divide steps and a rounding step. The back end takes a new
// word from the queue only once it is back in idle. Each result is shown for a single
// cycle on o_result_valid and must be taken then. The user must write pixel_count
// through i_cfg_wr_en only while no word is in flight; the block does not enforce it.

module flat_dark_pixel_calibration #(
    parameter int MAX_PIXELS = 16777216
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic [fdpc_pkg::OP_W-1:0]    i_operation,
    input  wire logic [fdpc_pkg::PIX_W-1:0]   i_light_pixel,
    input  wire logic [fdpc_pkg::MST_W-1:0]   i_dark_value,
    input  wire logic [fdpc_pkg::MST_W-1:0]   i_bias_value,
    input  wire logic [fdpc_pkg::MST_W-1:0]   i_flat_value,
    input  wire logic                         i_end_of_stack,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [fdpc_pkg::PC_W-1:0]    i_cfg_wr_data,
    output logic                              o_result_valid,
    output logic [fdpc_pkg::PIX_W-1:0]        o_calibrated_pixel,
    output logic                              o_zero_denominator,
    output logic                              o_last_pixel
);

    fdpc_pkg::t_q_status q_status;
    fdpc_pkg::t_job      push_job, head_job;
    logic                push, pop;

    fdpc_front #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_operation    (i_operation),
        .i_light_pixel  (i_light_pixel),
        .i_dark_value   (i_dark_value),
        .i_bias_value   (i_bias_value),
        .i_flat_value   (i_flat_value),
        .i_end_of_stack (i_end_of_stack),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_q_status     (q_status),
        .o_busy         (o_busy),
        .o_push         (push),
        .o_job          (push_job)
    );

    fdpc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    fdpc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_status         (q_status),
        .i_job              (head_job),
        .o_pop              (pop),
        .o_result_valid     (o_result_valid),
        .o_calibrated_pixel (o_calibrated_pixel),
        .o_zero_denominator (o_zero_denominator),
        .o_last_pixel       (o_last_pixel)
    );

endmodule

`default_nettype wire

### hdl/fdpc_front.sv
// Front end: accepts words, keeps the flat sum and pixel count, classifies calibrate words.
`timescale 1ns / 1ps
`default_nettype none

module fdpc_front #(
    parameter int MAX_PIXELS = 16777216
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [fdpc_pkg::OP_W-1:0]    i_operation,
    input  wire logic [fdpc_pkg::PIX_W-1:0]   i_light_pixel,
    input  wire logic [fdpc_pkg::MST_W-1:0]   i_dark_value,
    input  wire logic [fdpc_pkg::MST_W-1:0]   i_bias_value,
    input  wire logic [fdpc_pkg::MST_W-1:0]   i_flat_value,
    input  wire logic                         i_end_of_stack,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [fdpc_pkg::PC_W-1:0]    i_cfg_wr_data,
    input  wire fdpc_pkg::t_q_status          i_q_status,
    output logic                              o_busy,
    output logic                              o_push,
    output fdpc_pkg::t_job                    o_job
);

    localparam int PC_W  = fdpc_pkg::PC_W;
    localparam int SUM_W = fdpc_pkg::SUM_W;
    localparam int MST_W = fdpc_pkg::MST_W;
    localparam int PIX_W = fdpc_pkg::PIX_W;
    localparam logic [PC_W-1:0] PC_MAX = PC_W'(MAX_PIXELS);

    logic [SUM_W-1:0] r_flat_sum, n_flat_sum;
    logic [PC_W-1:0]  r_pixel_count, n_pixel_count;

    logic             accept;
    logic [MST_W-1:0] light_q8;
    logic             nneg, dneg;
    logic [MST_W-1:0] nmag, dmag;
    logic             sum_zero, pc_zero;
    logic [SUM_W:0]   sum_ext;

    assign accept   = i_start && !i_q_status.full;
    assign o_busy   = i_q_status.full;
    assign o_push   = accept && (i_operation == fdpc_pkg::OP_CALIB);

    assign light_q8 = {i_light_pixel, {fdpc_pkg::FRAC_W{1'b0}}};
    assign nneg     = i_dark_value > light_q8;
    assign nmag     = nneg ? (i_dark_value - light_q8) : (light_q8 - i_dark_value);
    assign dneg     = i_bias_value > i_flat_value;
    assign dmag     = dneg ? (i_bias_value - i_flat_value) : (i_flat_value - i_bias_value);
    assign sum_zero = (r_flat_sum == '0);
    assign pc_zero  = (r_pixel_count == '0);
    assign sum_ext  = {1'b0, r_flat_sum} + {{(SUM_W + 1 - MST_W){1'b0}}, i_flat_value};

    always_comb begin
        o_job        = '0;
        o_job.eos    = i_end_of_stack;
        o_job.nmag   = nmag;
        o_job.dmag   = dmag;
        o_job.fsum   = r_flat_sum;
        o_job.pcount = r_pixel_count;
        o_job.zflag  = (dmag == '0) || sum_zero || pc_zero;
        if ((dmag == '0) || pc_zero) begin
            // divide by zero: full scale only for a positive numerator
            o_job.pix = (!nneg && (nmag != '0) && !sum_zero) ? {PIX_W{1'b1}} : '0;
        end else if ((nmag == '0) || sum_zero || (nneg != dneg)) begin
            o_job.pix = '0;
        end else begin
            o_job.divide = 1'b1;
        end
    end

    always_comb begin
        n_flat_sum = r_flat_sum;
        if (accept) begin
            case (i_operation)
                fdpc_pkg::OP_ACCUM: begin
                    n_flat_sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                end
                fdpc_pkg::OP_CLEAR: begin
                    n_flat_sum = '0;
                end
                default: begin
                    n_flat_sum = r_flat_sum;
                end
            endcase
        end
    end

    always_comb begin
        n_pixel_count = r_pixel_count;
        if (i_cfg_wr_en) begin
            n_pixel_count = (i_cfg_wr_data > PC_MAX) ? PC_MAX : i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat_sum    <= '0;
            r_pixel_count <= PC_W'(1);
        end else begin
            r_flat_sum    <= n_flat_sum;
            r_pixel_count <= n_pixel_count;
        end
    end

endmodule

`default_nettype wire

### hdl/fdpc_queue.sv
// Two-entry queue of classified calibrate words between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module fdpc_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire fdpc_pkg::t_job     i_job,
    input  wire logic               i_pop,
    output fdpc_pkg::t_job          o_job,
    output fdpc_pkg::t_q_status     o_status
);

    localparam int DEPTH  = fdpc_pkg::Q_DEPTH;
    localparam int PTR_W  = fdpc_pkg::QPTR_W;
    localparam int CNT_W  = fdpc_pkg::QCNT_W;

    fdpc_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("queue read while empty");

endmodule

`default_nettype wire

### hdl/fdpc_back.sv
// Back end: split multiply, range check, restoring divide, rounding and result strobe.
`timescale 1ns / 1ps
`default_nettype none

module fdpc_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fdpc_pkg::t_q_status         i_q_status,
    input  wire fdpc_pkg::t_job              i_job,
    output logic                             o_pop,
    output logic                             o_result_valid,
    output logic [fdpc_pkg::PIX_W-1:0]       o_calibrated_pixel,
    output logic                             o_zero_denominator,
    output logic                             o_last_pixel
);

    localparam int PIX_W  = fdpc_pkg::PIX_W;
    localparam int FRAC_W = fdpc_pkg::FRAC_W;
    localparam int MST_W  = fdpc_pkg::MST_W;
    localparam int PC_W   = fdpc_pkg::PC_W;
    localparam int SUM_W  = fdpc_pkg::SUM_W;
    localparam int HALF_W = fdpc_pkg::HALF_W;
    localparam int PP_W   = fdpc_pkg::PP_W;
    localparam int PROD_W = fdpc_pkg::PROD_W;
    localparam int DEN_W  = fdpc_pkg::DEN_W;
    localparam int DIV_W  = fdpc_pkg::DIV_W;
    localparam int Q_W    = fdpc_pkg::Q_W;
    localparam int CNT_W  = fdpc_pkg::CNT_W;
    localparam int SAT_SH = fdpc_pkg::SAT_SH;

    fdpc_pkg::t_back_state r_state, n_state;

    logic [MST_W-1:0]  r_nmag, r_dmag;
    logic [SUM_W-1:0]  r_fsum;
    logic [PC_W-1:0]   r_pcount;
    logic              r_zflag, r_eos;
    logic [PP_W-1:0]   r_pp;
    logic [DEN_W-1:0]  r_den;
    logic [PROD_W-1:0] r_acc;
    logic [DIV_W-1:0]  r_rem, r_div;
    logic [Q_W-1:0]    r_low, r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pix;
    logic              r_out_zflag, r_out_eos;

    logic [PP_W-1:0]   pp_lo, pp_hi;
    logic [DEN_W-1:0]  den_prod;
    logic              too_big;
    logic [DIV_W:0]    trial, trial_diff;
    logic              trial_ge;
    logic [Q_W:0]      q_inc;
    logic [PIX_W-1:0]  q_round;
    logic              sat_hit, round_hit, bypass_hit;

    assign pp_lo    = r_nmag * r_fsum[HALF_W-1:0];
    assign pp_hi    = r_nmag * r_fsum[SUM_W-1:HALF_W];
    assign den_prod = r_dmag * r_pcount;

    // quotient of 2^16 or more saturates; divisor is den << 8, so compare against den << 24
    assign too_big  = {1'b0, r_acc} >= {r_den, {SAT_SH{1'b0}}};

    assign trial      = {r_rem, r_low[Q_W-1]};
    assign trial_ge   = trial >= {1'b0, r_div};
    assign trial_diff = trial - {1'b0, r_div};

    // quotient carries one half bit: (q + 1) >> 1 rounds half up
    assign q_inc   = {1'b0, r_q} + 1'b1;
    assign q_round = q_inc[Q_W] ? {PIX_W{1'b1}} : q_inc[Q_W-1:1];

    assign o_pop      = (r_state == fdpc_pkg::ST_IDLE) && !i_q_status.empty;
    assign bypass_hit = o_pop && !i_job.divide;
    assign sat_hit    = (r_state == fdpc_pkg::ST_CHECK) && too_big;
    assign round_hit  = (r_state == fdpc_pkg::ST_ROUND);

    always_comb begin
        n_state = r_state;
        case (r_state)
            fdpc_pkg::ST_IDLE: begin
                if (o_pop && i_job.divide) begin
                    n_state = fdpc_pkg::ST_MUL0;
                end
            end
            fdpc_pkg::ST_MUL0:  n_state = fdpc_pkg::ST_MUL1;
            fdpc_pkg::ST_MUL1:  n_state = fdpc_pkg::ST_MUL2;
            fdpc_pkg::ST_MUL2:  n_state = fdpc_pkg::ST_CHECK;
            fdpc_pkg::ST_CHECK: n_state = too_big ? fdpc_pkg::ST_IDLE : fdpc_pkg::ST_DIV;
            fdpc_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = fdpc_pkg::ST_ROUND;
                end
            end
            fdpc_pkg::ST_ROUND: n_state = fdpc_pkg::ST_IDLE;
            default:            n_state = fdpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fdpc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= bypass_hit || sat_hit || round_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bypass_hit) begin
            r_pix       <= i_job.pix;
            r_out_zflag <= i_job.zflag;
            r_out_eos   <= i_job.eos;
        end else if (sat_hit) begin
            r_pix       <= {PIX_W{1'b1}};
            r_out_zflag <= r_zflag;
            r_out_eos   <= r_eos;
        end else if (round_hit) begin
            r_pix       <= q_round;
            r_out_zflag <= r_zflag;
            r_out_eos   <= r_eos;
        end

        case (r_state)
            fdpc_pkg::ST_IDLE: begin
                if (o_pop) begin
                    r_nmag   <= i_job.nmag;
                    r_dmag   <= i_job.dmag;
                    r_fsum   <= i_job.fsum;
                    r_pcount <= i_job.pcount;
                    r_zflag  <= i_job.zflag;
                    r_eos    <= i_job.eos;
                end
            end
            fdpc_pkg::ST_MUL0: begin
                r_pp  <= pp_lo;
                r_den <= den_prod;
            end
            fdpc_pkg::ST_MUL1: begin
                r_acc <= {{(PROD_W - PP_W){1'b0}}, r_pp};
                r_pp  <= pp_hi;
            end
            fdpc_pkg::ST_MUL2: begin
                r_acc <= r_acc + {r_pp, {HALF_W{1'b0}}};
            end
            fdpc_pkg::ST_CHECK: begin
                // remainder starts with numerator >> 16, which is below the divisor here
                r_rem <= {{(DIV_W - (PROD_W - PIX_W)){1'b0}}, r_acc[PROD_W-1:PIX_W]};
                r_low <= {r_acc[PIX_W-1:0], 1'b0};
                r_div <= {r_den, {FRAC_W{1'b0}}};
                r_q   <= '0;
                r_cnt <= CNT_W'(Q_W - 1);
            end
            fdpc_pkg::ST_DIV: begin
                r_rem <= trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
                r_low <= {r_low[Q_W-2:0], 1'b0};
                r_q   <= {r_q[Q_W-2:0], trial_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_result_valid     = r_out_valid;
    assign o_calibrated_pixel = r_pix;
    assign o_zero_denominator = r_out_zflag;
    assign o_last_pixel       = r_out_eos;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fdpc_pkg::ST_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == fdpc_pkg::ST_IDLE
                         || $past(r_state) == fdpc_pkg::ST_CHECK
                         || $past(r_state) == fdpc_pkg::ST_ROUND))
        else $error("result strobe from a busy back-end state");

    a_divide_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_job.divide) |=> (r_state == fdpc_pkg::ST_MUL0))
        else $error("divide word did not start the multiplier");

endmodule

`default_nettype wire
